[design/des_pkg.sv]
// Package for the delayed event scheduler: request and result beat types,
// request and result codes, stored entry layout. No dependencies.
`default_nettype none
package des_pkg;

	localparam int REM_W = 15;

	localparam logic [1:0] REQ_SCHEDULE = 2'd0;
	localparam logic [1:0] REQ_TICK     = 2'd1;
	localparam logic [1:0] REQ_CLEAR    = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [15:0]      sound_id;
		logic [31:0]      sound_arg;
		logic [REM_W-1:0] delay_frames;
		logic [7:0]       tick_step;
	} sched_req_t;

	typedef struct packed {
		logic        result_kind;
		logic        accepted;
		logic [15:0] fired_id;
		logic [31:0] fired_arg;
		logic        last;
	} sched_rsp_t;

	// survivors always hold a countdown above zero, so it is kept unsigned
	typedef struct packed {
		logic [15:0]      sound;
		logic [31:0]      argument;
		logic [REM_W-1:0] remaining;
	} entry_t;

endpackage
`default_nettype wire

[design/delayed_event_scheduler_core.sv]
// Delayed event scheduler: event list in one synchronous memory, walked and
// compacted by a read-modify-write sequencer. Depends on des_pkg.
//
// Schedule and clear keep busy low; a schedule's status beat follows in the next cycle.
// A tick holds busy while it reads each entry in turn, waits out the read latency and drains;
// on an empty list busy is high for one cycle only.
// Fired beats appear in list order while busy is high; the last one comes as busy falls.
// The receiver cannot stall: every result beat is shown for exactly one cycle.
// Reset empties the list; the entry memory itself is not cleared.
`default_nettype none
module delayed_event_scheduler_core
	import des_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire sched_req_t req,
	output logic            busy,
	output logic            result_valid,
	output sched_rsp_t      result
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [0:0] {ST_IDLE, ST_WALK} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rd_idx_q;
	logic [CW-1:0]    wr_idx_q;
	logic             vld_s1;
	entry_t           rdata_s1;
	logic             pend_vld_q;
	logic [15:0]      pend_id_q;
	logic [31:0]      pend_arg_q;
	logic [7:0]       step_q;
	sched_rsp_t       result_q;

	entry_t           mem [SLOTS];

	logic             accept;
	logic             full;
	logic             sched_wr;
	logic             issue;
	logic             fire;
	logic             keep;
	logic             walk_done;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	entry_t           mem_wdata;

	assign busy         = (state_q != ST_IDLE);
	assign result       = result_q;
	assign accept       = start && !busy;
	assign full         = (count_q == CW'(SLOTS));
	assign sched_wr     = accept && (req.req_type == REQ_SCHEDULE) && !full;
	assign issue        = (state_q == ST_WALK) && (rd_idx_q != count_q);
	assign fire         = vld_s1 && (rdata_s1.remaining <= REM_W'(step_q));
	assign keep         = vld_s1 && !fire;
	assign walk_done    = (state_q == ST_WALK) && (rd_idx_q == count_q) && !vld_s1;

	always_comb begin
		mem_we    = sched_wr || keep;
		mem_waddr = sched_wr ? count_q[IW-1:0] : wr_idx_q[IW-1:0];
		if (sched_wr) begin
			mem_wdata.sound     = req.sound_id;
			mem_wdata.argument  = req.sound_arg;
			mem_wdata.remaining = req.delay_frames;
		end else begin
			mem_wdata.sound     = rdata_s1.sound;
			mem_wdata.argument  = rdata_s1.argument;
			mem_wdata.remaining = rdata_s1.remaining - REM_W'(step_q);
		end
	end

	// writes trail reads (wr_idx <= rd_idx), so no same-entry overlap
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[rd_idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			wr_idx_q     <= '0;
			vld_s1       <= 1'b0;
			pend_vld_q   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						case (req.req_type)
							REQ_SCHEDULE: begin
								result_valid <= 1'b1;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							REQ_TICK: begin
								state_q    <= ST_WALK;
								rd_idx_q   <= '0;
								wr_idx_q   <= '0;
								pend_vld_q <= 1'b0;
							end
							REQ_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					vld_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (keep) begin
						wr_idx_q <= wr_idx_q + CW'(1);
					end
					if (fire) begin
						pend_vld_q <= 1'b1;
						if (pend_vld_q) begin
							result_valid <= 1'b1;
						end
					end
					if (walk_done) begin
						count_q      <= wr_idx_q;
						result_valid <= pend_vld_q;
						pend_vld_q   <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// one fired event is held back so the last one of a tick can be marked
	always_ff @(posedge clk) begin
		if (accept && (req.req_type == REQ_TICK)) begin
			step_q <= req.tick_step;
		end
		if (fire) begin
			pend_id_q  <= rdata_s1.sound;
			pend_arg_q <= rdata_s1.argument;
		end
		if (accept && (req.req_type == REQ_SCHEDULE)) begin
			result_q.result_kind <= KIND_STATUS;
			result_q.accepted    <= !full;
			result_q.fired_id    <= '0;
			result_q.fired_arg   <= '0;
			result_q.last        <= 1'b0;
		end else if (fire || walk_done) begin
			result_q.result_kind <= KIND_FIRED;
			result_q.accepted    <= 1'b0;
			result_q.fired_id    <= pend_id_q;
			result_q.fired_arg   <= pend_arg_q;
			result_q.last        <= walk_done;
		end
	end

endmodule
`default_nettype wire

[design/des_checker.sv]
// Port-level checks for delayed_event_scheduler_core, bound into every instance of it.
// Depends on des_pkg.
`default_nettype none
module des_checker
	import des_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire sched_req_t req,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire sched_rsp_t result
);

	a_sched_status: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_SCHEDULE)
		|=> result_valid && (result.result_kind == KIND_STATUS))
		else $error("schedule beat without status result");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_CLEAR) |=> !result_valid && !busy)
		else $error("clear produced a result or went busy");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_TICK) |=> busy)
		else $error("tick beat did not start a walk");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == KIND_STATUS)
		|-> !result.last && (result.fired_id == 16'd0) && (result.fired_arg == 32'd0))
		else $error("status result carries event fields");

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == KIND_FIRED) |-> (result.last == !busy))
		else $error("last marker does not match end of tick");

endmodule

bind delayed_event_scheduler_core des_checker u_des_checker (.*);
`default_nettype wire
